// File: rtl/atan2pa_pkg.sv
// shared types, widths and fixed-point constants for the atan2 polynomial unit
`timescale 1ns / 1ps

package atan2pa_pkg;

    localparam int COORD_WIDTH        = 16;
    localparam int ANGLE_FRAC_BITS    = 13;
    localparam int ANGLE_WIDTH        = ANGLE_FRAC_BITS + 3;

    localparam int RATIO_WIDTH        = 16;
    localparam int DIV_BITS_PER_STAGE = 2;
    localparam int DIV_STAGES         = RATIO_WIDTH / DIV_BITS_PER_STAGE;

    localparam int SQ_WIDTH           = 2 * RATIO_WIDTH;
    localparam int P_WIDTH            = 32;
    localparam int HMUL_WIDTH         = P_WIDTH + SQ_WIDTH + 1;
    localparam int FMUL_WIDTH         = P_WIDTH + RATIO_WIDTH + 1;
    localparam int A_WIDTH            = 34;
    localparam int Q_FRAC             = 30;
    localparam int ANGLE_SHIFT        = Q_FRAC - ANGLE_FRAC_BITS;
    localparam int HORNER_STEPS       = 5;

    localparam logic [RATIO_WIDTH-1:0] RATIO_MAX = {RATIO_WIDTH{1'b1}};

    // decimal constants with nine fractional digits, scaled by 2^30, rounded to nearest
    localparam logic signed [63:0] Q_ONE   = 64'sd1073741824;
    localparam logic signed [63:0] Q_HALF  = 64'sd500000000;
    localparam logic signed [63:0] Q_DEC   = 64'sd1000000000;

    localparam logic signed [63:0] K_C5_Q  = (64'sd13480470 * Q_ONE + Q_HALF) / Q_DEC;
    localparam logic signed [63:0] K_C4_Q  = (64'sd57477314 * Q_ONE + Q_HALF) / Q_DEC;
    localparam logic signed [63:0] K_C3_Q  = (64'sd121239071 * Q_ONE + Q_HALF) / Q_DEC;
    localparam logic signed [63:0] K_C2_Q  = (64'sd195635925 * Q_ONE + Q_HALF) / Q_DEC;
    localparam logic signed [63:0] K_C1_Q  = (64'sd332994597 * Q_ONE + Q_HALF) / Q_DEC;
    localparam logic signed [63:0] K_C0_Q  = (64'sd999995630 * Q_ONE + Q_HALF) / Q_DEC;
    localparam logic signed [63:0] K_HPI_Q = (64'sd1570796327 * Q_ONE + Q_HALF) / Q_DEC;
    localparam logic signed [63:0] K_PI_Q  = (64'sd3141592654 * Q_ONE + Q_HALF) / Q_DEC;

    localparam logic signed [P_WIDTH-1:0] K_P_INIT  = P_WIDTH'(-K_C5_Q);
    localparam logic signed [A_WIDTH-1:0] K_HALF_PI = A_WIDTH'(K_HPI_Q);
    localparam logic signed [A_WIDTH-1:0] K_PI      = A_WIDTH'(K_PI_Q);

    localparam int ANGLE_LIMIT =
        int'((K_PI_Q + (64'sd1 <<< (ANGLE_SHIFT - 1))) >>> ANGLE_SHIFT);

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] coord_x;
        logic signed [COORD_WIDTH-1:0] coord_y;
    } t_in;

    typedef struct packed {
        logic signed [ANGLE_WIDTH-1:0] angle;
        logic                          both_zero;
    } t_out;

    typedef struct packed {
        logic zero;
        logic swap;
        logic xneg;
        logic yneg;
    } t_side;

    typedef struct packed {
        logic                   vld;
        t_side                  side;
        logic [RATIO_WIDTH-1:0] r;
    } t_ratio;

    typedef struct packed {
        logic                   vld;
        t_side                  side;
        logic [RATIO_WIDTH-1:0] r;
        logic [SQ_WIDTH-1:0]    s;
    } t_pctl;

    typedef struct packed {
        logic                        vld;
        t_side                       side;
        logic [RATIO_WIDTH-1:0]      r;
        logic signed [P_WIDTH-1:0]   p;
    } t_poly;

    // horner coefficients in order of use, signs applied
    function automatic logic signed [P_WIDTH-1:0] horner_coef(input int k);
        case (k)
            0:       horner_coef = P_WIDTH'(K_C4_Q);
            1:       horner_coef = P_WIDTH'(-K_C3_Q);
            2:       horner_coef = P_WIDTH'(K_C2_Q);
            3:       horner_coef = P_WIDTH'(-K_C1_Q);
            default: horner_coef = P_WIDTH'(K_C0_Q);
        endcase
    endfunction

endpackage

// File: rtl/atan2pa_div.sv
// magnitude, octant compare and pipelined restoring divider for the ratio
`timescale 1ns / 1ps

module atan2pa_div import atan2pa_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  logic   i_valid,
    input  t_in    i_data,
    output t_ratio o_ratio
);

    logic [COORD_WIDTH-1:0] ax;
    logic [COORD_WIDTH-1:0] ay;
    logic                   xneg;
    logic                   yneg;

    logic [COORD_WIDTH:0]   r_rem  [0:DIV_STAGES-1];
    logic [COORD_WIDTH-1:0] r_mx   [0:DIV_STAGES-1];
    logic [RATIO_WIDTH-1:0] r_q    [0:DIV_STAGES];
    logic                   r_eq   [0:DIV_STAGES];
    t_side                  r_side [0:DIV_STAGES];
    logic                   r_vld  [0:DIV_STAGES];

    always_comb begin
        xneg = i_data.coord_x[COORD_WIDTH-1];
        yneg = i_data.coord_y[COORD_WIDTH-1];
        ax   = xneg ? ($unsigned(~i_data.coord_x) + COORD_WIDTH'(1))
                    : $unsigned(i_data.coord_x);
        ay   = yneg ? ($unsigned(~i_data.coord_y) + COORD_WIDTH'(1))
                    : $unsigned(i_data.coord_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mx[0]        <= (ax > ay) ? ax : ay;
            r_rem[0]       <= {1'b0, ((ax > ay) ? ay : ax)};
            r_q[0]         <= '0;
            r_eq[0]        <= (ax == ay);
            r_side[0].zero <= (ax == '0) && (ay == '0);
            r_side[0].swap <= (ay > ax);
            r_side[0].xneg <= xneg;
            r_side[0].yneg <= yneg;
        end
    end

    for (genvar i = 1; i <= DIV_STAGES; i++) begin : g_stage
        logic [COORD_WIDTH:0]   n_rem;
        logic [RATIO_WIDTH-1:0] n_q;

        always_comb begin
            n_rem = r_rem[i-1];
            n_q   = r_q[i-1];
            for (int j = 0; j < DIV_BITS_PER_STAGE; j++) begin
                n_rem = {n_rem[COORD_WIDTH-1:0], 1'b0};
                if (n_rem >= {1'b0, r_mx[i-1]}) begin
                    n_rem = n_rem - {1'b0, r_mx[i-1]};
                    n_q   = {n_q[RATIO_WIDTH-2:0], 1'b1};
                end else begin
                    n_q   = {n_q[RATIO_WIDTH-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i] <= 1'b0;
            end else if (i_en) begin
                r_vld[i] <= r_vld[i-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[i]    <= n_q;
                r_eq[i]   <= r_eq[i-1];
                r_side[i] <= r_side[i-1];
            end
        end

        if (i < DIV_STAGES) begin : g_fwd
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[i] <= n_rem;
                    r_mx[i]  <= r_mx[i-1];
                end
            end
        end
    end

    // equal magnitudes saturate the ratio
    always_comb begin
        o_ratio.vld  = r_vld[DIV_STAGES];
        o_ratio.side = r_side[DIV_STAGES];
        o_ratio.r    = r_eq[DIV_STAGES] ? RATIO_MAX : r_q[DIV_STAGES];
    end

endmodule

// File: rtl/atan2pa_poly.sv
// squared ratio and pipelined horner evaluation of the odd polynomial
`timescale 1ns / 1ps

module atan2pa_poly import atan2pa_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  t_ratio i_ratio,
    output t_poly  o_poly
);

    t_pctl                        r_sq_ctl;
    t_pctl                        r_mctl [0:HORNER_STEPS-1];
    t_pctl                        r_actl [0:HORNER_STEPS-1];
    logic signed [HMUL_WIDTH-1:0] r_prod [0:HORNER_STEPS-1];
    logic signed [P_WIDTH-1:0]    r_p    [0:HORNER_STEPS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_ctl.vld <= 1'b0;
        end else if (i_en) begin
            r_sq_ctl.vld <= i_ratio.vld;
        end
        if (i_en) begin
            r_sq_ctl.side <= i_ratio.side;
            r_sq_ctl.r    <= i_ratio.r;
            r_sq_ctl.s    <= i_ratio.r * i_ratio.r;
        end
    end

    for (genvar k = 0; k < HORNER_STEPS; k++) begin : g_step
        logic signed [P_WIDTH-1:0]    p_in;
        t_pctl                        ctl_in;
        logic signed [HMUL_WIDTH-1:0] n_rnd;
        logic signed [P_WIDTH-1:0]    n_p;

        if (k == 0) begin : g_first
            assign p_in   = K_P_INIT;
            assign ctl_in = r_sq_ctl;
        end else begin : g_next
            assign p_in   = r_p[k-1];
            assign ctl_in = r_actl[k-1];
        end

        // round to nearest, ties up, then add the next coefficient
        always_comb begin
            n_rnd = r_prod[k] + (HMUL_WIDTH'(1) <<< (SQ_WIDTH - 1));
            n_p   = $signed(n_rnd[SQ_WIDTH+P_WIDTH-1:SQ_WIDTH]) + horner_coef(k);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_mctl[k].vld <= 1'b0;
                r_actl[k].vld <= 1'b0;
            end else if (i_en) begin
                r_mctl[k].vld <= ctl_in.vld;
                r_actl[k].vld <= r_mctl[k].vld;
            end
            if (i_en) begin
                r_prod[k]      <= p_in * $signed({1'b0, ctl_in.s});
                r_mctl[k].side <= ctl_in.side;
                r_mctl[k].r    <= ctl_in.r;
                r_mctl[k].s    <= ctl_in.s;
                r_p[k]         <= n_p;
                r_actl[k].side <= r_mctl[k].side;
                r_actl[k].r    <= r_mctl[k].r;
                r_actl[k].s    <= r_mctl[k].s;
            end
        end
    end

    always_comb begin
        o_poly.vld  = r_actl[HORNER_STEPS-1].vld;
        o_poly.side = r_actl[HORNER_STEPS-1].side;
        o_poly.r    = r_actl[HORNER_STEPS-1].r;
        o_poly.p    = r_p[HORNER_STEPS-1];
    end

endmodule

// File: rtl/atan2pa_fix.sv
// final ratio product, octant corrections, output rounding and output register
`timescale 1ns / 1ps

module atan2pa_fix import atan2pa_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  t_poly i_poly,
    output logic  o_valid,
    output t_out  o_data
);

    logic                         r_m_vld;
    t_side                        r_m_side;
    logic signed [FMUL_WIDTH-1:0] r_m_prod;

    logic                         r_a_vld;
    t_side                        r_a_side;
    logic signed [A_WIDTH-1:0]    r_a1;

    logic                         r_b_vld;
    t_side                        r_b_side;
    logic signed [A_WIDTH-1:0]    r_a3;

    logic                         r_out_vld;
    t_out                         r_out;

    logic signed [FMUL_WIDTH-1:0] n_rnd;
    logic signed [A_WIDTH-1:0]    n_a;
    logic signed [A_WIDTH-1:0]    n_a1;
    logic signed [A_WIDTH-1:0]    n_term_a;
    logic signed [A_WIDTH-1:0]    n_term_pi;
    logic signed [A_WIDTH:0]      n_ang_rnd;

    always_comb begin
        n_rnd     = r_m_prod + (FMUL_WIDTH'(1) <<< (RATIO_WIDTH - 1));
        n_a       = A_WIDTH'($signed(n_rnd[RATIO_WIDTH+P_WIDTH-1:RATIO_WIDTH]));
        n_a1      = r_m_side.swap ? (K_HALF_PI - n_a) : n_a;
        // pi - a then negate, folded into one add
        n_term_a  = (r_a_side.xneg ^ r_a_side.yneg) ? -r_a1 : r_a1;
        n_term_pi = !r_a_side.xneg ? '0 : (r_a_side.yneg ? -K_PI : K_PI);
        n_ang_rnd = (A_WIDTH+1)'(r_a3) + ((A_WIDTH+1)'(1) <<< (ANGLE_SHIFT - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld   <= 1'b0;
            r_a_vld   <= 1'b0;
            r_b_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_m_vld   <= i_poly.vld;
            r_a_vld   <= r_m_vld;
            r_b_vld   <= r_a_vld;
            r_out_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m_prod <= i_poly.p * $signed({1'b0, i_poly.r});
            r_m_side <= i_poly.side;
            r_a1     <= n_a1;
            r_a_side <= r_m_side;
            r_a3     <= n_term_a + n_term_pi;
            r_b_side <= r_a_side;
            if (r_b_side.zero) begin
                r_out.angle     <= '0;
                r_out.both_zero <= 1'b1;
            end else begin
                r_out.angle     <= $signed(n_ang_rnd[ANGLE_SHIFT+ANGLE_WIDTH-1:ANGLE_SHIFT]);
                r_out.both_zero <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

endmodule

// File: rtl/atan2_poly_approx_unit.sv
// top level: four-quadrant arctangent by ratio, odd polynomial and octant fix-up
// each input transfer passes the divider, horner and final stages in turn to a result
// throughput one coordinate pair per cycle while the output is not stalled; every stage is registered
// a stalled output freezes the whole pipeline, input stall follows output stall
// synchronous active-low reset clears the valid bits only
`timescale 1ns / 1ps

module atan2_poly_approx_unit import atan2pa_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_in  i_data,
    output logic o_stall,
    output logic o_valid,
    output t_out o_data,
    input  logic i_stall
);

    logic   en;
    t_ratio ratio;
    t_poly  poly;

    assign o_stall = o_valid && i_stall;
    assign en      = !o_stall;

    atan2pa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_ratio (ratio)
    );

    atan2pa_poly u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ratio (ratio),
        .o_poly  (poly)
    );

    atan2pa_fix u_fix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_poly  (poly),
        .o_valid (o_valid),
        .o_data  (o_data)
    );

endmodule

// File: rtl/atan2pa_checker.sv
// port-level checks on the atan2 unit and the bind that attaches them
`timescale 1ns / 1ps

module atan2pa_checker import atan2pa_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input t_in  i_data,
    input logic o_stall,
    input logic o_valid,
    input t_out o_data,
    input logic i_stall
);

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_data))
        else $error("stalled input transfer changed or vanished");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("stalled result changed or vanished");

    a_zero_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.both_zero |-> o_data.angle == '0)
        else $error("both-zero result with nonzero angle");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a stalled result");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.angle <= ANGLE_LIMIT && o_data.angle >= -ANGLE_LIMIT)
        else $error("angle outside plus or minus pi");

endmodule

bind atan2_poly_approx_unit atan2pa_checker u_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .i_data  (i_data),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .o_data  (o_data),
    .i_stall (i_stall)
);
